/* hw/rtl/hsvrgb_pkg.sv */
// hsvrgb_pkg: hue constants, sector codes and hue sector helpers for hsv_to_rgb_convert
// no dependencies
package hsvrgb_pkg;

	localparam int HUE_W      = 13;
	localparam int FRAC_W     = 10;
	localparam int HUE_SECTOR = 960;
	localparam int HUE_FULL   = 5760;

	// one code per 60 degree sector of the color wheel
	typedef enum logic [2:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5
	} sector_t;

	// sector of a wrapped hue, by comparing against the sector bounds
	function automatic sector_t hue_sector(input logic [HUE_W-1:0] h);
		sector_t sec;
		sec = SEC_R_TO_Y;
		if (h >= HUE_W'(5 * HUE_SECTOR))
			sec = SEC_M_TO_R;
		else if (h >= HUE_W'(4 * HUE_SECTOR))
			sec = SEC_B_TO_M;
		else if (h >= HUE_W'(3 * HUE_SECTOR))
			sec = SEC_C_TO_B;
		else if (h >= HUE_W'(2 * HUE_SECTOR))
			sec = SEC_G_TO_C;
		else if (h >= HUE_W'(HUE_SECTOR))
			sec = SEC_Y_TO_G;
		return sec;
	endfunction

	// first hue of a sector
	function automatic logic [HUE_W-1:0] sector_base(input sector_t sec);
		logic [HUE_W-1:0] base;
		case (sec)
			SEC_R_TO_Y: base = '0;
			SEC_Y_TO_G: base = HUE_W'(HUE_SECTOR);
			SEC_G_TO_C: base = HUE_W'(2 * HUE_SECTOR);
			SEC_C_TO_B: base = HUE_W'(3 * HUE_SECTOR);
			SEC_B_TO_M: base = HUE_W'(4 * HUE_SECTOR);
			SEC_M_TO_R: base = HUE_W'(5 * HUE_SECTOR);
			default:    base = '0;
		endcase
		return base;
	endfunction

endpackage

/* hw/rtl/hsvrgb_div_m.sv */
// hsvrgb_div_m: two-stage exact divider by the constant 2^CHANNEL_BITS - 1
// no dependencies; estimate by folded shifts, then one remainder correction
module hsvrgb_div_m #(
	parameter int CHANNEL_BITS = 8,
	parameter int IN_W         = 16
) (
	input  logic                         clk,
	input  logic                         en_a,
	input  logic                         en_b,
	input  logic [IN_W-1:0]              x,
	output logic [IN_W-CHANNEL_BITS:0]   q
);

	localparam int N  = CHANNEL_BITS;
	localparam int QW = IN_W - N + 1;
	localparam int RW = IN_W + 2;

	logic [IN_W:0]   fold;
	logic [QW-1:0]   est;
	logic [QW-1:0]   est_q;
	logic [IN_W-1:0] x_q;
	logic [RW-1:0]   rem;

	// x / (2^N - 1) = sum of x >> kN; low by at most one after truncation
	assign fold = {1'b0, x} + ({1'b0, x} >> N) + ({1'b0, x} >> (2 * N));
	assign est  = fold[IN_W:N];

	always_ff @(posedge clk) begin
		if (en_a) begin
			est_q <= est;
			x_q   <= x;
		end
	end

	assign rem = RW'(x_q) + RW'(est_q) - (RW'(est_q) << N);

	always_ff @(posedge clk) begin
		if (en_b) begin
			q <= (rem >= RW'((1 << N) - 1)) ? est_q + QW'(1) : est_q;
		end
	end

endmodule

/* hw/rtl/hsv_to_rgb_convert.sv */
// hsv_to_rgb_convert: seven-stage pipeline from accepted input word to output word
// throughput one word per cycle unless stalled; a stage holds its word while the next stalls
// s_axis_tready is high whenever stage 1 is empty or can move on, even with the output stalled
// asynchronous reset clears only the stage valid bits; the data registers are left as they are
// uses hsvrgb_pkg and hsvrgb_div_m
module hsv_to_rgb_convert #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	// input word: hue [12:0], saturation, brightness, zero fill to bytes
	input  logic                                          s_axis_tvalid,
	output logic                                          s_axis_tready,
	input  logic [((13 + 2 * CHANNEL_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// output word: red, green, blue, zero fill to bytes
	output logic                                          m_axis_tvalid,
	input  logic                                          m_axis_tready,
	output logic [((3 * CHANNEL_BITS + 7) / 8) * 8 - 1:0]      m_axis_tdata
);

	localparam int N      = CHANNEL_BITS;
	localparam int HW     = hsvrgb_pkg::HUE_W;
	localparam int FW     = hsvrgb_pkg::FRAC_W;
	localparam int OUT_W  = ((3 * N + 7) / 8) * 8;
	// denominator of q and t: full scale times one sector
	localparam int DW     = N + FW;
	localparam int unsigned DEN_I = ((1 << N) - 1) * hsvrgb_pkg::HUE_SECTOR;
	localparam logic [DW-1:0] DEN = DW'(DEN_I);
	localparam logic [N-1:0]  MAXV = '1;
	// q and t: divide by 64, then by full scale, then by 15 through a reciprocal
	localparam int QW     = N + 5;
	localparam int RK     = N + 8;
	localparam logic [QW-1:0] RECIP = QW'(((64'd1 << RK) + 64'd14) / 64'd15);
	localparam int PW     = 2 * N + FW;

	// stage handshake
	logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, vld7_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	// input fields
	logic [HW-1:0] hue_in;
	logic [N-1:0]  sat_in;
	logic [N-1:0]  val_in;
	logic [HW-1:0] hue_wrap;
	hsvrgb_pkg::sector_t sector_in;

	// stage 1: sector and position inside it
	hsvrgb_pkg::sector_t sector_s1;
	logic [FW-1:0] frac_s1;
	logic [N-1:0]  sat_s1;
	logic [N-1:0]  val_s1;

	// stage 2: first products
	hsvrgb_pkg::sector_t sector_s2;
	logic [2*N-1:0] pn_s2;
	logic [DW-1:0]  sf_s2;
	logic [DW-1:0]  sg_s2;
	logic [N-1:0]   val_s2;

	// stage 3: numerators, q and t already divided by 64
	hsvrgb_pkg::sector_t sector_s3;
	logic [2*N-1:0]  pn_s3;
	logic [PW-1:0]   qprod;
	logic [PW-1:0]   tprod;
	logic [2*N+3:0]  qn_s3;
	logic [2*N+3:0]  tn_s3;
	logic [N-1:0]    val_s3;

	// stages 4 and 5: division by full scale inside the dividers
	hsvrgb_pkg::sector_t sector_s4, sector_s5;
	logic [N-1:0]  val_s4, val_s5;
	logic [N:0]    pm;
	logic [QW-1:0] qm;
	logic [QW-1:0] tm;

	// stage 6: reciprocal products for the division by 15
	hsvrgb_pkg::sector_t sector_s6;
	logic [PW-1:0] qz_s6;
	logic [PW-1:0] tz_s6;
	logic [N-1:0]  p_s6;
	logic [N-1:0]  val_s6;
	logic [N-1:0]  q_lvl;
	logic [N-1:0]  t_lvl;

	// stage 7: output register
	logic [N-1:0] red_s7, green_s7, blue_s7, val_s7;

	assign hue_in = s_axis_tdata[HW-1:0];
	assign sat_in = s_axis_tdata[HW +: N];
	assign val_in = s_axis_tdata[HW+N +: N];

	// ready ripples back from the output; an empty stage always takes a word
	assign rdy7 = !vld7_q || m_axis_tready;
	assign rdy6 = !vld6_q || rdy7;
	assign rdy5 = !vld5_q || rdy6;
	assign rdy4 = !vld4_q || rdy5;
	assign rdy3 = !vld3_q || rdy4;
	assign rdy2 = !vld2_q || rdy3;
	assign rdy1 = !vld1_q || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld1_q <= 1'b0;
			vld2_q <= 1'b0;
			vld3_q <= 1'b0;
			vld4_q <= 1'b0;
			vld5_q <= 1'b0;
			vld6_q <= 1'b0;
			vld7_q <= 1'b0;
		end else begin
			if (rdy1) vld1_q <= s_axis_tvalid;
			if (rdy2) vld2_q <= vld1_q;
			if (rdy3) vld3_q <= vld2_q;
			if (rdy4) vld4_q <= vld3_q;
			if (rdy5) vld5_q <= vld4_q;
			if (rdy6) vld6_q <= vld5_q;
			if (rdy7) vld7_q <= vld6_q;
		end
	end

	// full turn and anything beyond it wrap to hue zero
	assign hue_wrap  = (hue_in >= HW'(hsvrgb_pkg::HUE_FULL)) ? '0 : hue_in;
	assign sector_in = hsvrgb_pkg::hue_sector(hue_wrap);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			sector_s1 <= sector_in;
			frac_s1   <= FW'(hue_wrap - hsvrgb_pkg::sector_base(sector_in));
			sat_s1    <= sat_in;
			val_s1    <= val_in;
		end
	end

	// p numerator and the two saturation-times-position terms
	always_ff @(posedge clk) begin
		if (rdy2) begin
			sector_s2 <= sector_s1;
			pn_s2     <= (2*N)'(val_s1) * (2*N)'(MAXV - sat_s1);
			sf_s2     <= DW'(sat_s1) * DW'(frac_s1);
			sg_s2     <= DW'(sat_s1) * DW'(FW'(hsvrgb_pkg::HUE_SECTOR) - frac_s1);
			val_s2    <= val_s1;
		end
	end

	// sf and sg never exceed the denominator, so the differences never go negative
	assign qprod = PW'(val_s2) * PW'(DEN - sf_s2);
	assign tprod = PW'(val_s2) * PW'(DEN - sg_s2);

	always_ff @(posedge clk) begin
		if (rdy3) begin
			sector_s3 <= sector_s2;
			pn_s3     <= pn_s2;
			qn_s3     <= qprod[PW-1:6];
			tn_s3     <= tprod[PW-1:6];
			val_s3    <= val_s2;
		end
	end

	hsvrgb_div_m #(.CHANNEL_BITS(N), .IN_W(2 * N)) u_div_p (
		.clk  (clk),
		.en_a (rdy4),
		.en_b (rdy5),
		.x    (pn_s3),
		.q    (pm)
	);

	hsvrgb_div_m #(.CHANNEL_BITS(N), .IN_W(2 * N + 4)) u_div_q (
		.clk  (clk),
		.en_a (rdy4),
		.en_b (rdy5),
		.x    (qn_s3),
		.q    (qm)
	);

	hsvrgb_div_m #(.CHANNEL_BITS(N), .IN_W(2 * N + 4)) u_div_t (
		.clk  (clk),
		.en_a (rdy4),
		.en_b (rdy5),
		.x    (tn_s3),
		.q    (tm)
	);

	always_ff @(posedge clk) begin
		if (rdy4) begin
			sector_s4 <= sector_s3;
			val_s4    <= val_s3;
		end
		if (rdy5) begin
			sector_s5 <= sector_s4;
			val_s5    <= val_s4;
		end
	end

	// the last division, by 15, is a multiply by a rounded-up reciprocal
	always_ff @(posedge clk) begin
		if (rdy6) begin
			sector_s6 <= sector_s5;
			qz_s6     <= PW'(qm) * PW'(RECIP);
			tz_s6     <= PW'(tm) * PW'(RECIP);
			p_s6      <= pm[N-1:0];
			val_s6    <= val_s5;
		end
	end

	assign q_lvl = qz_s6[RK +: N];
	assign t_lvl = tz_s6[RK +: N];

	// sector picks the order of v, p, q and t on the three channels
	always_ff @(posedge clk) begin
		if (rdy7) begin
			val_s7 <= val_s6;
			case (sector_s6)
				hsvrgb_pkg::SEC_R_TO_Y: begin
					red_s7 <= val_s6; green_s7 <= t_lvl;  blue_s7 <= p_s6;
				end
				hsvrgb_pkg::SEC_Y_TO_G: begin
					red_s7 <= q_lvl;  green_s7 <= val_s6; blue_s7 <= p_s6;
				end
				hsvrgb_pkg::SEC_G_TO_C: begin
					red_s7 <= p_s6;   green_s7 <= val_s6; blue_s7 <= t_lvl;
				end
				hsvrgb_pkg::SEC_C_TO_B: begin
					red_s7 <= p_s6;   green_s7 <= q_lvl;  blue_s7 <= val_s6;
				end
				hsvrgb_pkg::SEC_B_TO_M: begin
					red_s7 <= t_lvl;  green_s7 <= p_s6;   blue_s7 <= val_s6;
				end
				default: begin
					red_s7 <= val_s6; green_s7 <= p_s6;   blue_s7 <= q_lvl;
				end
			endcase
		end
	end

	assign m_axis_tvalid = vld7_q;
	assign m_axis_tdata  = OUT_W'({blue_s7, green_s7, red_s7});

	// a stalled mid-pipeline word keeps its valid bit and its sector
	assert property (@(posedge clk) disable iff (!arst_n)
		vld6_q && !rdy6 |=> vld6_q && $stable(sector_s6))
		else $error("stage 6 word changed while stalled");

	// no channel can exceed the brightness it was derived from
	assert property (@(posedge clk) disable iff (!arst_n)
		vld7_q |-> (red_s7 <= val_s7) && (green_s7 <= val_s7) && (blue_s7 <= val_s7))
		else $error("channel level above brightness");

	// a full output register that is not taken blocks stage 6 from moving on
	assert property (@(posedge clk) disable iff (!arst_n)
		vld7_q && !m_axis_tready && vld6_q |-> !rdy6)
		else $error("stage 6 advanced into a stalled output register");

endmodule

/* tb/sv/hsv_to_rgb_convert_checker.sv */
// hsv_to_rgb_convert_checker: watches both stream channels of hsv_to_rgb_convert,
// predicts the rgb word for every accepted hsv word and compares in order
// depends on hsvrgb_pkg for the hue constants and sector codes
module hsv_to_rgb_convert_checker #(
	parameter int CHANNEL_BITS = 8,
	parameter int IN_W         = ((13 + 2 * CHANNEL_BITS + 7) / 8) * 8,
	parameter int OUT_W        = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,
	output int               mismatches,
	output int               pixels_waiting
);

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] blue;
		logic [CHANNEL_BITS-1:0] green;
		logic [CHANNEL_BITS-1:0] red;
	} rgb_t;

	typedef struct {
		logic [hsvrgb_pkg::HUE_W-1:0] hue;
		logic [CHANNEL_BITS-1:0]      sat;
		logic [CHANNEL_BITS-1:0]      val;
		rgb_t                         rgb;
	} pixel_t;

	pixel_t expected_pixels[$];

	initial begin
		mismatches     = 0;
		pixels_waiting = 0;
	end

	// exact rational hsv to rgb with truncation
	function automatic rgb_t hsv_to_rgb(input logic [hsvrgb_pkg::HUE_W-1:0] hue,
			input logic [CHANNEL_BITS-1:0] sat, input logic [CHANNEL_BITS-1:0] val);
		longint unsigned h, s, v, full, den, frac, p, q, t;
		hsvrgb_pkg::sector_t sec;
		rgb_t px;
		h    = hue;
		s    = sat;
		v    = val;
		full = (longint'(1) << CHANNEL_BITS) - 1;
		den  = full * hsvrgb_pkg::HUE_SECTOR;
		// a full turn and anything past it fold to red
		if (h >= hsvrgb_pkg::HUE_FULL)
			h = 0;
		if (s == 0) begin
			px.red   = CHANNEL_BITS'(v);
			px.green = CHANNEL_BITS'(v);
			px.blue  = CHANNEL_BITS'(v);
			return px;
		end
		sec  = hsvrgb_pkg::sector_t'(3'(h / hsvrgb_pkg::HUE_SECTOR));
		frac = h % hsvrgb_pkg::HUE_SECTOR;
		p    = (v * (full - s)) / full;
		q    = (v * (den - s * frac)) / den;
		t    = (v * (den - s * (hsvrgb_pkg::HUE_SECTOR - frac))) / den;
		case (sec)
			hsvrgb_pkg::SEC_R_TO_Y:
				px = '{blue: CHANNEL_BITS'(p), green: CHANNEL_BITS'(t),
					red: CHANNEL_BITS'(v)};
			hsvrgb_pkg::SEC_Y_TO_G:
				px = '{blue: CHANNEL_BITS'(p), green: CHANNEL_BITS'(v),
					red: CHANNEL_BITS'(q)};
			hsvrgb_pkg::SEC_G_TO_C:
				px = '{blue: CHANNEL_BITS'(t), green: CHANNEL_BITS'(v),
					red: CHANNEL_BITS'(p)};
			hsvrgb_pkg::SEC_C_TO_B:
				px = '{blue: CHANNEL_BITS'(v), green: CHANNEL_BITS'(q),
					red: CHANNEL_BITS'(p)};
			hsvrgb_pkg::SEC_B_TO_M:
				px = '{blue: CHANNEL_BITS'(v), green: CHANNEL_BITS'(p),
					red: CHANNEL_BITS'(t)};
			default:
				px = '{blue: CHANNEL_BITS'(q), green: CHANNEL_BITS'(p),
					red: CHANNEL_BITS'(v)};
		endcase
		return px;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_channel(input string name, input pixel_t px,
			input logic [CHANNEL_BITS-1:0] got, input logic [CHANNEL_BITS-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d (hue %0d sat %0d val %0d)",
				name, got, want, px.hue, px.sat, px.val));
	endtask

	always @(posedge clk) begin
		pixel_t px;
		rgb_t got;
		if (arst_n) begin
			// retire first so a word leaving now never pairs with one entering now
			if (m_tvalid && m_tready) begin
				got = rgb_t'(m_tdata[3*CHANNEL_BITS-1:0]);
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("output word %0h with nothing pending", m_tdata));
				end else begin
					px = expected_pixels.pop_front();
					check_channel("red", px, got.red, px.rgb.red);
					check_channel("green", px, got.green, px.rgb.green);
					check_channel("blue", px, got.blue, px.rgb.blue);
				end
			end
			if (s_tvalid && s_tready) begin
				px.hue = s_tdata[hsvrgb_pkg::HUE_W-1:0];
				px.sat = s_tdata[hsvrgb_pkg::HUE_W +: CHANNEL_BITS];
				px.val = s_tdata[hsvrgb_pkg::HUE_W + CHANNEL_BITS +: CHANNEL_BITS];
				px.rgb = hsv_to_rgb(px.hue, px.sat, px.val);
				expected_pixels.push_back(px);
			end
		end
		pixels_waiting = expected_pixels.size();
	end

endmodule

/* tb/sv/tb_hsv_to_rgb_convert.sv */
// tb_hsv_to_rgb_convert: stimulus and verdict for the hsv_to_rgb_convert pipeline
// drives directed corner colors, then random colors under three idling mixes
// depends on hsvrgb_pkg, hsv_to_rgb_convert and hsv_to_rgb_convert_checker
module tb_hsv_to_rgb_convert;

	localparam int CHANNEL_BITS = 8;
	localparam int HUE_W        = hsvrgb_pkg::HUE_W;
	localparam int CHAN_MAX     = (1 << CHANNEL_BITS) - 1;
	localparam int IN_W         = ((13 + 2 * CHANNEL_BITS + 7) / 8) * 8;
	localparam int OUT_W        = ((3 * CHANNEL_BITS + 7) / 8) * 8;
	localparam int HUE_MAX      = (1 << HUE_W) - 1;
	// random words per idling mix, three mixes in all
	localparam int WORDS_PER_MIX = 420;
	// more than the seven-stage pipeline latency
	localparam int FLUSH_CYCLES  = 16;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;   // hue, saturation, brightness, zero fill
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;   // red, green, blue, zero fill
	int               mismatches;
	int               pixels_waiting;

	// percent of cycles each side holds off
	int send_idle_pct;
	int recv_idle_pct;

	hsv_to_rgb_convert #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	hsv_to_rgb_convert_checker #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_axis_tvalid),
		.s_tready      (s_axis_tready),
		.s_tdata       (s_axis_tdata),
		.m_tvalid      (m_axis_tvalid),
		.m_tready      (m_axis_tready),
		.m_tdata       (m_axis_tdata),
		.mismatches    (mismatches),
		.pixels_waiting(pixels_waiting)
	);

	// 20 unit period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// receiver stalls at random, redrawn every cycle
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// hold one hsv word on the input until it is taken, with random gaps ahead of it
	task automatic send_hsv(input logic [HUE_W-1:0] hue, input logic [CHANNEL_BITS-1:0] sat,
			input logic [CHANNEL_BITS-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_W'({val, sat, hue});
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// mostly in-range hues with extra weight on sector edges, grey and full levels
	task automatic send_random_hsv();
		logic [HUE_W-1:0]        hue;
		logic [CHANNEL_BITS-1:0] sat;
		logic [CHANNEL_BITS-1:0] val;
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			hue = HUE_W'(hsvrgb_pkg::HUE_SECTOR * $urandom_range(6) + $urandom_range(2) - 1);
		else if (pick < 16)
			hue = HUE_W'($urandom_range(HUE_MAX, hsvrgb_pkg::HUE_FULL));
		else
			hue = HUE_W'($urandom_range(hsvrgb_pkg::HUE_FULL));
		pick = $urandom_range(99);
		if (pick < 10)
			sat = '0;
		else if (pick < 20)
			sat = CHANNEL_BITS'(CHAN_MAX);
		else
			sat = CHANNEL_BITS'($urandom_range(CHAN_MAX));
		pick = $urandom_range(99);
		if (pick < 5)
			val = '0;
		else if (pick < 15)
			val = CHANNEL_BITS'(CHAN_MAX);
		else
			val = CHANNEL_BITS'($urandom_range(CHAN_MAX));
		send_hsv(hue, sat, val);
	endtask

	// sender goes quiet until every predicted word has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pixels_waiting != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		send_idle_pct = 25;
		recv_idle_pct = 55;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sector edges at full saturation and value
		send_hsv(13'd0, 8'd255, 8'd255);
		send_hsv(13'd959, 8'd255, 8'd255);
		send_hsv(13'd960, 8'd255, 8'd255);
		send_hsv(13'd1919, 8'd255, 8'd255);
		send_hsv(13'd1920, 8'd255, 8'd255);
		send_hsv(13'd2879, 8'd255, 8'd255);
		send_hsv(13'd2880, 8'd255, 8'd255);
		send_hsv(13'd3840, 8'd255, 8'd255);
		send_hsv(13'd4800, 8'd255, 8'd255);
		send_hsv(13'd5759, 8'd255, 8'd255);
		// full turn, just past it and the largest hue code all fold to red
		send_hsv(13'd5760, 8'd255, 8'd255);
		send_hsv(13'd5761, 8'd200, 8'd255);
		send_hsv(13'd8191, 8'd255, 8'd255);
		// grey with zero saturation
		send_hsv(13'd480, 8'd0, 8'd200);
		send_hsv(13'd3000, 8'd0, 8'd255);
		// black, faintest saturation and mid-sector blends
		send_hsv(13'd2000, 8'd255, 8'd0);
		send_hsv(13'd4000, 8'd1, 8'd255);
		send_hsv(13'd480, 8'd128, 8'd255);
		send_hsv(13'd1440, 8'd170, 8'd85);
		send_hsv(13'd5000, 8'd85, 8'd170);
		send_hsv(13'd2400, 8'd254, 8'd254);
		// alternating bit patterns across every field
		send_hsv(13'h0AAA, 8'h55, 8'hAA);
		send_hsv(13'h1555, 8'hAA, 8'h55);
		drain();

		for (int i = 0; i < WORDS_PER_MIX; i++)
			send_random_hsv();
		drain();

		send_idle_pct = 55;
		recv_idle_pct = 25;
		for (int i = 0; i < WORDS_PER_MIX; i++)
			send_random_hsv();
		drain();

		// back to back with the output always ready
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < WORDS_PER_MIX; i++)
			send_random_hsv();
		drain();

		repeat (FLUSH_CYCLES) @(posedge clk);
		if (mismatches == 0 && pixels_waiting == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

/* hsv_to_rgb_convert.f */
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_div_m.sv
hw/rtl/hsv_to_rgb_convert.sv
tb/sv/hsv_to_rgb_convert_checker.sv
tb/sv/tb_hsv_to_rgb_convert.sv
